// ----- rtl/core/complex_autocorrelator_lags_0_to_2_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the complex autocorrelator
// Shorthands for the concurrent checks used inside the RTL modules.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_AUTOCORRELATOR_LAGS_0_TO_2_MACROS_SVH
`define COMPLEX_AUTOCORRELATOR_LAGS_0_TO_2_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CAC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CAC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cac_pkg.sv -----
// ----------------------------------------------------------------------------
// cac_pkg
// Shared widths, constants and types of the complex autocorrelator.
// ----------------------------------------------------------------------------
package cac_pkg;

   localparam int MAX_SAMPLES = 64;

   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 6;
   localparam int COUNT_W  = $clog2(MAX_SAMPLES);
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int TERM_W   = PROD_W + 1;
   localparam int ACC_W    = 38;
   localparam int ENERGY_W = 37;

   localparam int LEN_MIN          = 1;
   localparam int LEN_MAX          = MAX_SAMPLES - 2;
   localparam int SUM_LENGTH_RESET = 38;

   // Per-item control that travels down the pipeline with the operands.
   typedef struct packed {
      logic en_lag0;
      logic en_lag1;
      logic en_lag2;
      logic last;
   } cac_flags_type;

   // Current sample and the two samples before it.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] b_re;
      logic signed [SAMPLE_W-1:0] b_im;
      logic signed [SAMPLE_W-1:0] a1_re;
      logic signed [SAMPLE_W-1:0] a1_im;
      logic signed [SAMPLE_W-1:0] a2_re;
      logic signed [SAMPLE_W-1:0] a2_im;
   } cac_operands_type;

   // One step's contribution to each accumulator.
   typedef struct packed {
      logic signed [TERM_W-1:0] lag1_re;
      logic signed [TERM_W-1:0] lag1_im;
      logic signed [TERM_W-1:0] lag2_re;
      logic signed [TERM_W-1:0] lag2_im;
      logic signed [TERM_W-1:0] lag0;
   } cac_terms_type;

endpackage

// ----- rtl/core/complex_autocorrelator_lags_0_to_2.sv -----
// ----------------------------------------------------------------------------
// complex_autocorrelator_lags_0_to_2
// Streaming complex autocorrelator producing lag-0, lag-1 and lag-2 sums.
//
// Complex Q1.15 samples arrive one per transfer on the req_ channel. Samples
// 0 to len+1 form one block, where len is csr_write_data as last written
// (reset value 38; a value of zero acts as 1 and 63 acts as 62). Sample 0 of a
// block is taken and not used. Over i = 1..len-1 the block sums, exactly and
// without rounding at Q2.30 scale, the energy re*re + im*im and the lag-1 and
// lag-2 correlations of x[i] with conjugated x[i+1] and x[i+2]. The transfer
// of sample len+1 produces one rsp_ transfer carrying lag1 real, lag1 imag,
// lag2 real, lag2 imag and lag0 energy, and clears the block. The pipeline is
// an input register, a product register holding the ten 16x16 products
// folded into five terms, and the accumulators feeding the result register,
// which takes the sums as the closing sample leaves the product register.
// A new sample is taken on every cycle; the pipeline holds only when a
// closing sample reaches the accumulators while the previous result still
// waits for rsp_ready. Since a block spans at least three samples, the
// input never stalls while rsp_ready stays high.
// The sum length is to be written only while no samples are in flight.
// ----------------------------------------------------------------------------
module complex_autocorrelator_lags_0_to_2 (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cac_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [cac_pkg::SAMPLE_W-1:0]  req_sample_im,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cac_pkg::ACC_W-1:0]     rsp_lag1_real,
   output logic signed [cac_pkg::ACC_W-1:0]     rsp_lag1_imag,
   output logic signed [cac_pkg::ACC_W-1:0]     rsp_lag2_real,
   output logic signed [cac_pkg::ACC_W-1:0]     rsp_lag2_imag,
   output logic        [cac_pkg::ENERGY_W-1:0]  rsp_lag0_energy,

   input  logic                                 csr_write_enable,
   input  logic        [cac_pkg::LEN_W-1:0]     csr_write_data
);

   // Pipeline advance: low only while a closing sample sits in the product
   // register and the result register holds a result that is not taken in
   // this cycle. Every stage moves together on this signal.
   logic                              advance;

   logic [cac_pkg::LEN_W-1:0]         sum_length_ff, sum_length_in;

   logic                              s1_valid;
   cac_pkg::cac_flags_type            s1_flags;
   cac_pkg::cac_operands_type         s1_ops;

   logic                              s2_valid;
   cac_pkg::cac_flags_type            s2_flags;
   cac_pkg::cac_terms_type            s2_terms;

   assign advance   = !(s2_valid && s2_flags.last && rsp_valid && !rsp_ready);
   assign req_ready = advance;

   // Sum length register; the raw value is kept and clamped where it is used.
   assign sum_length_in = csr_write_enable ? csr_write_data : sum_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_length_ff <= cac_pkg::LEN_W'(cac_pkg::SUM_LENGTH_RESET);
      end else begin
         sum_length_ff <= sum_length_in;
      end
   end

   // Front: tracks the position within the block and the two previous
   // samples, decides which lags this sample contributes to, and registers
   // the operands.
   cac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_valid  (req_valid),
      .sample_re  (req_sample_re),
      .sample_im  (req_sample_im),
      .sum_length (sum_length_ff),
      .s1_valid   (s1_valid),
      .s1_flags   (s1_flags),
      .s1_ops     (s1_ops)
   );

   // Products: one registered stage of ten multipliers.
   cac_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .s1_valid (s1_valid),
      .s1_flags (s1_flags),
      .s1_ops   (s1_ops),
      .s2_valid (s2_valid),
      .s2_flags (s2_flags),
      .s2_terms (s2_terms)
   );

   // Accumulators and the result register; the closing sample's terms are
   // included in the result it produces.
   cac_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .s2_valid    (s2_valid),
      .s2_flags    (s2_flags),
      .s2_terms    (s2_terms),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .lag1_real   (rsp_lag1_real),
      .lag1_imag   (rsp_lag1_imag),
      .lag2_real   (rsp_lag2_real),
      .lag2_imag   (rsp_lag2_imag),
      .lag0_energy (rsp_lag0_energy)
   );

endmodule

// ----- rtl/core/cac_front.sv -----
// ----------------------------------------------------------------------------
// cac_front
// Sample history, position counter and the input register of the pipeline.
// ----------------------------------------------------------------------------
`include "complex_autocorrelator_lags_0_to_2_macros.svh"

module cac_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   req_valid,
   input  logic signed [cac_pkg::SAMPLE_W-1:0]    sample_re,
   input  logic signed [cac_pkg::SAMPLE_W-1:0]    sample_im,
   input  logic        [cac_pkg::LEN_W-1:0]       sum_length,
   output logic                                   s1_valid,
   output cac_pkg::cac_flags_type                 s1_flags,
   output cac_pkg::cac_operands_type              s1_ops
);

   localparam int CMP_W = cac_pkg::COUNT_W + 1;

   logic                                 accept;
   logic [cac_pkg::LEN_W-1:0]            len;
   logic [CMP_W-1:0]                     j_ext;
   logic [CMP_W-1:0]                     len_ext;
   cac_pkg::cac_flags_type               flags_in;
   cac_pkg::cac_operands_type            ops_in;

   logic [cac_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic signed [cac_pkg::SAMPLE_W-1:0]  prev0_re_ff, prev0_re_in;
   logic signed [cac_pkg::SAMPLE_W-1:0]  prev0_im_ff, prev0_im_in;
   logic signed [cac_pkg::SAMPLE_W-1:0]  prev1_re_ff, prev1_re_in;
   logic signed [cac_pkg::SAMPLE_W-1:0]  prev1_im_ff, prev1_im_in;
   logic                                 s1_valid_ff;
   cac_pkg::cac_flags_type               s1_flags_ff;
   cac_pkg::cac_operands_type            s1_ops_ff;

   assign accept = req_valid && advance;

   // A length of zero acts as one; the top code acts as the largest legal length.
   always_comb begin
      len = sum_length;
      if (sum_length < cac_pkg::LEN_W'(cac_pkg::LEN_MIN)) begin
         len = cac_pkg::LEN_W'(cac_pkg::LEN_MIN);
      end else if (sum_length > cac_pkg::LEN_W'(cac_pkg::LEN_MAX)) begin
         len = cac_pkg::LEN_W'(cac_pkg::LEN_MAX);
      end
   end

   assign j_ext   = CMP_W'(count_ff);
   assign len_ext = CMP_W'(len);

   always_comb begin
      flags_in.en_lag0 = (j_ext >= CMP_W'(1)) && (j_ext < len_ext);
      flags_in.en_lag1 = (j_ext >= CMP_W'(2)) && (j_ext <= len_ext);
      flags_in.en_lag2 = (j_ext >= CMP_W'(3)) && (j_ext <= len_ext + CMP_W'(1));
      flags_in.last    = (j_ext > len_ext);
   end

   always_comb begin
      ops_in.b_re  = sample_re;
      ops_in.b_im  = sample_im;
      ops_in.a1_re = prev0_re_ff;
      ops_in.a1_im = prev0_im_ff;
      ops_in.a2_re = prev1_re_ff;
      ops_in.a2_im = prev1_im_ff;
   end

   always_comb begin
      count_in    = count_ff;
      prev0_re_in = prev0_re_ff;
      prev0_im_in = prev0_im_ff;
      prev1_re_in = prev1_re_ff;
      prev1_im_in = prev1_im_ff;
      if (accept) begin
         if (flags_in.last) begin
            count_in    = '0;
            prev0_re_in = '0;
            prev0_im_in = '0;
            prev1_re_in = '0;
            prev1_im_in = '0;
         end else begin
            count_in    = count_ff + cac_pkg::COUNT_W'(1);
            prev0_re_in = sample_re;
            prev0_im_in = sample_im;
            prev1_re_in = prev0_re_ff;
            prev1_im_in = prev0_im_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prev0_re_ff <= '0;
         prev0_im_ff <= '0;
         prev1_re_ff <= '0;
         prev1_im_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         prev0_re_ff <= prev0_re_in;
         prev0_im_ff <= prev0_im_in;
         prev1_re_ff <= prev1_re_in;
         prev1_im_ff <= prev1_im_in;
         if (advance) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff <= flags_in;
         s1_ops_ff   <= ops_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_flags = s1_flags_ff;
   assign s1_ops   = s1_ops_ff;

   // The position never passes one beyond the largest sum length.
   `CAC_ASSERT_ALWAYS(a_count_in_range, clock, reset,
      count_ff <= cac_pkg::COUNT_W'(cac_pkg::LEN_MAX + 1), "sample position out of range")

endmodule

// ----- rtl/core/cac_mult.sv -----
// ----------------------------------------------------------------------------
// cac_mult
// Product stage: forms the lag-0, lag-1 and lag-2 terms of one sample.
// ----------------------------------------------------------------------------
module cac_mult (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          s1_valid,
   input  cac_pkg::cac_flags_type        s1_flags,
   input  cac_pkg::cac_operands_type     s1_ops,
   output logic                          s2_valid,
   output cac_pkg::cac_flags_type        s2_flags,
   output cac_pkg::cac_terms_type        s2_terms
);

   function automatic logic signed [cac_pkg::TERM_W-1:0] sum_of_products(
      input logic signed [cac_pkg::SAMPLE_W-1:0] a,
      input logic signed [cac_pkg::SAMPLE_W-1:0] b,
      input logic signed [cac_pkg::SAMPLE_W-1:0] c,
      input logic signed [cac_pkg::SAMPLE_W-1:0] d
   );
      logic signed [cac_pkg::PROD_W-1:0] ab;
      logic signed [cac_pkg::PROD_W-1:0] cd;
      ab = a * b;
      cd = c * d;
      return cac_pkg::TERM_W'(ab) + cac_pkg::TERM_W'(cd);
   endfunction

   function automatic logic signed [cac_pkg::TERM_W-1:0] diff_of_products(
      input logic signed [cac_pkg::SAMPLE_W-1:0] a,
      input logic signed [cac_pkg::SAMPLE_W-1:0] b,
      input logic signed [cac_pkg::SAMPLE_W-1:0] c,
      input logic signed [cac_pkg::SAMPLE_W-1:0] d
   );
      logic signed [cac_pkg::PROD_W-1:0] ab;
      logic signed [cac_pkg::PROD_W-1:0] cd;
      ab = a * b;
      cd = c * d;
      return cac_pkg::TERM_W'(ab) - cac_pkg::TERM_W'(cd);
   endfunction

   cac_pkg::cac_terms_type   terms_in;
   logic                     s2_valid_ff;
   cac_pkg::cac_flags_type   s2_flags_ff;
   cac_pkg::cac_terms_type   s2_terms_ff;

   // The newer sample is conjugated: re*re' + im*im' and im*re' - re*im'.
   always_comb begin
      terms_in.lag0    = sum_of_products(s1_ops.b_re, s1_ops.b_re, s1_ops.b_im, s1_ops.b_im);
      terms_in.lag1_re = sum_of_products(s1_ops.a1_re, s1_ops.b_re, s1_ops.a1_im, s1_ops.b_im);
      terms_in.lag1_im = diff_of_products(s1_ops.a1_im, s1_ops.b_re, s1_ops.a1_re, s1_ops.b_im);
      terms_in.lag2_re = sum_of_products(s1_ops.a2_re, s1_ops.b_re, s1_ops.a2_im, s1_ops.b_im);
      terms_in.lag2_im = diff_of_products(s1_ops.a2_im, s1_ops.b_re, s1_ops.a2_re, s1_ops.b_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_flags_ff <= s1_flags;
         s2_terms_ff <= terms_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_flags = s2_flags_ff;
   assign s2_terms = s2_terms_ff;

endmodule

// ----- rtl/core/cac_accum.sv -----
// ----------------------------------------------------------------------------
// cac_accum
// Five exact accumulators and the result register of the block.
// ----------------------------------------------------------------------------
`include "complex_autocorrelator_lags_0_to_2_macros.svh"

module cac_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 s2_valid,
   input  cac_pkg::cac_flags_type               s2_flags,
   input  cac_pkg::cac_terms_type               s2_terms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cac_pkg::ACC_W-1:0]     lag1_real,
   output logic signed [cac_pkg::ACC_W-1:0]     lag1_imag,
   output logic signed [cac_pkg::ACC_W-1:0]     lag2_real,
   output logic signed [cac_pkg::ACC_W-1:0]     lag2_imag,
   output logic        [cac_pkg::ENERGY_W-1:0]  lag0_energy
);

   logic                                 step;
   logic                                 emit;

   logic signed [cac_pkg::ACC_W-1:0]     sum_lag1_re, sum_lag1_im;
   logic signed [cac_pkg::ACC_W-1:0]     sum_lag2_re, sum_lag2_im;
   logic        [cac_pkg::ENERGY_W-1:0]  sum_lag0;

   logic signed [cac_pkg::ACC_W-1:0]     acc_lag1_re_ff, acc_lag1_re_in;
   logic signed [cac_pkg::ACC_W-1:0]     acc_lag1_im_ff, acc_lag1_im_in;
   logic signed [cac_pkg::ACC_W-1:0]     acc_lag2_re_ff, acc_lag2_re_in;
   logic signed [cac_pkg::ACC_W-1:0]     acc_lag2_im_ff, acc_lag2_im_in;
   logic        [cac_pkg::ENERGY_W-1:0]  acc_lag0_ff, acc_lag0_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [cac_pkg::ACC_W-1:0]     lag1_real_ff, lag1_imag_ff;
   logic signed [cac_pkg::ACC_W-1:0]     lag2_real_ff, lag2_imag_ff;
   logic        [cac_pkg::ENERGY_W-1:0]  lag0_energy_ff;

   assign step = advance && s2_valid;
   assign emit = step && s2_flags.last;

   // Running sums including this step's terms; a disabled lag adds nothing.
   always_comb begin
      sum_lag1_re = acc_lag1_re_ff;
      sum_lag1_im = acc_lag1_im_ff;
      sum_lag2_re = acc_lag2_re_ff;
      sum_lag2_im = acc_lag2_im_ff;
      sum_lag0    = acc_lag0_ff;
      if (s2_flags.en_lag1) begin
         sum_lag1_re = acc_lag1_re_ff + cac_pkg::ACC_W'($signed(s2_terms.lag1_re));
         sum_lag1_im = acc_lag1_im_ff + cac_pkg::ACC_W'($signed(s2_terms.lag1_im));
      end
      if (s2_flags.en_lag2) begin
         sum_lag2_re = acc_lag2_re_ff + cac_pkg::ACC_W'($signed(s2_terms.lag2_re));
         sum_lag2_im = acc_lag2_im_ff + cac_pkg::ACC_W'($signed(s2_terms.lag2_im));
      end
      if (s2_flags.en_lag0) begin
         // Energy terms are never negative, so the sign bit is dropped.
         sum_lag0 = acc_lag0_ff
                  + cac_pkg::ENERGY_W'(s2_terms.lag0[cac_pkg::TERM_W-2:0]);
      end
   end

   always_comb begin
      acc_lag1_re_in = acc_lag1_re_ff;
      acc_lag1_im_in = acc_lag1_im_ff;
      acc_lag2_re_in = acc_lag2_re_ff;
      acc_lag2_im_in = acc_lag2_im_ff;
      acc_lag0_in    = acc_lag0_ff;
      if (emit) begin
         acc_lag1_re_in = '0;
         acc_lag1_im_in = '0;
         acc_lag2_re_in = '0;
         acc_lag2_im_in = '0;
         acc_lag0_in    = '0;
      end else if (step) begin
         acc_lag1_re_in = sum_lag1_re;
         acc_lag1_im_in = sum_lag1_im;
         acc_lag2_re_in = sum_lag2_re;
         acc_lag2_im_in = sum_lag2_im;
         acc_lag0_in    = sum_lag0;
      end
   end

   // A new result fills the slot; otherwise a waiting result stays until it
   // is taken. A closing sample only steps when the slot is free or draining.
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_lag1_re_ff <= '0;
         acc_lag1_im_ff <= '0;
         acc_lag2_re_ff <= '0;
         acc_lag2_im_ff <= '0;
         acc_lag0_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         acc_lag1_re_ff <= acc_lag1_re_in;
         acc_lag1_im_ff <= acc_lag1_im_in;
         acc_lag2_re_ff <= acc_lag2_re_in;
         acc_lag2_im_ff <= acc_lag2_im_in;
         acc_lag0_ff    <= acc_lag0_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         lag1_real_ff   <= sum_lag1_re;
         lag1_imag_ff   <= sum_lag1_im;
         lag2_real_ff   <= sum_lag2_re;
         lag2_imag_ff   <= sum_lag2_im;
         lag0_energy_ff <= sum_lag0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign lag1_real   = lag1_real_ff;
   assign lag1_imag   = lag1_imag_ff;
   assign lag2_real   = lag2_real_ff;
   assign lag2_imag   = lag2_imag_ff;
   assign lag0_energy = lag0_energy_ff;

   // The block's closing sample leaves every accumulator cleared.
   `CAC_ASSERT_NEXT(a_clear_after_emit, clock, reset, emit,
      (acc_lag1_re_ff == '0) && (acc_lag1_im_ff == '0) && (acc_lag2_re_ff == '0)
      && (acc_lag2_im_ff == '0) && (acc_lag0_ff == '0),
      "accumulators not cleared after a result")
   // A new result appears only after a closing sample left the product stage.
   `CAC_ASSERT_IMPLIES(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff),
      $past(emit), "result raised without a closing sample")
   // A sample inside the block never produces a result.
   `CAC_ASSERT_NEXT(a_no_rsp_mid_block, clock, reset,
      step && !s2_flags.last && (rsp_ready || !rsp_valid_ff),
      !rsp_valid_ff, "result raised for a sample inside the block")

endmodule

// ----- tb/cac_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Correlation result checker
// Watches the sample, result and length-register ports of the complex
// autocorrelator, keeps its own model of the lag sums and compares every
// result transfer, field by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module cac_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [cac_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [cac_pkg::SAMPLE_W-1:0]  req_sample_im,

   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [cac_pkg::ACC_W-1:0]     rsp_lag1_real,
   input  logic signed [cac_pkg::ACC_W-1:0]     rsp_lag1_imag,
   input  logic signed [cac_pkg::ACC_W-1:0]     rsp_lag2_real,
   input  logic signed [cac_pkg::ACC_W-1:0]     rsp_lag2_imag,
   input  logic        [cac_pkg::ENERGY_W-1:0]  rsp_lag0_energy,

   input  logic                                 csr_write_enable,
   input  logic        [cac_pkg::LEN_W-1:0]     csr_write_data,

   output int                                   error_count,
   output int                                   pending_count
);
   import cac_pkg::*;

   typedef enum int {
      SUM_LAG1_RE,
      SUM_LAG1_IM,
      SUM_LAG2_RE,
      SUM_LAG2_IM,
      SUM_LAG0
   } sum_slot_type;

   typedef struct packed {
      logic [ACC_W-1:0]    lag1_real;
      logic [ACC_W-1:0]    lag1_imag;
      logic [ACC_W-1:0]    lag2_real;
      logic [ACC_W-1:0]    lag2_imag;
      logic [ENERGY_W-1:0] lag0_energy;
   } corr_result_type;

   corr_result_type            expected_results [$];
   logic signed [SAMPLE_W-1:0] hist_re [2];
   logic signed [SAMPLE_W-1:0] hist_im [2];
   logic [6:0]                 sample_index;
   logic [ACC_W-1:0]           lag_sums [5];
   logic [LEN_W-1:0]           sum_length;
   int                         mismatches = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [ACC_W-1:0] got,
                              input logic [ACC_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   task automatic clear_block();
      for (int k = 0; k < 2; k++) begin
         hist_re[k] = '0;
         hist_im[k] = '0;
      end
      for (int k = 0; k < 5; k++) begin
         lag_sums[k] = '0;
      end
      sample_index = '0;
   endtask

   // The sums wrap at the accumulator width, although in range they never do.
   task automatic add_term(input sum_slot_type slot, input longint term);
      lag_sums[slot] = lag_sums[slot] + term[ACC_W-1:0];
   endtask

   task automatic advance_correlator(input logic signed [SAMPLE_W-1:0] b_re,
                                     input logic signed [SAMPLE_W-1:0] b_im);
      int unsigned     len;
      int unsigned     j;
      longint          cur_re, cur_im, p1_re, p1_im, p2_re, p2_im;
      corr_result_type done;
      len = sum_length;
      if (len < LEN_MIN) len = LEN_MIN;
      if (len > LEN_MAX) len = LEN_MAX;
      j      = sample_index;
      cur_re = b_re;
      cur_im = b_im;
      p1_re  = hist_re[0];
      p1_im  = hist_im[0];
      p2_re  = hist_re[1];
      p2_im  = hist_im[1];

      if (j >= 1 && j + 1 <= len) begin
         add_term(SUM_LAG0, cur_re * cur_re + cur_im * cur_im);
      end
      if (j >= 2 && j <= len) begin
         add_term(SUM_LAG1_RE, p1_re * cur_re + p1_im * cur_im);
         add_term(SUM_LAG1_IM, p1_im * cur_re - p1_re * cur_im);
      end
      if (j >= 3 && j <= len + 1) begin
         add_term(SUM_LAG2_RE, p2_re * cur_re + p2_im * cur_im);
         add_term(SUM_LAG2_IM, p2_im * cur_re - p2_re * cur_im);
      end

      // The closing sample, or any sample once a shorter length has left the
      // index past the end, releases the sums and starts a fresh block.
      if (j >= len + 1) begin
         done.lag1_real   = lag_sums[SUM_LAG1_RE];
         done.lag1_imag   = lag_sums[SUM_LAG1_IM];
         done.lag2_real   = lag_sums[SUM_LAG2_RE];
         done.lag2_imag   = lag_sums[SUM_LAG2_IM];
         done.lag0_energy = lag_sums[SUM_LAG0][ENERGY_W-1:0];
         expected_results.push_back(done);
         clear_block();
      end else begin
         hist_re[1]   = hist_re[0];
         hist_im[1]   = hist_im[0];
         hist_re[0]   = b_re;
         hist_im[0]   = b_im;
         sample_index = sample_index + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      corr_result_type want;
      if (reset) begin
         clear_block();
         sum_length = LEN_W'(SUM_LENGTH_RESET);
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with no result pending");
            end else begin
               want = expected_results.pop_front();
               check_field("lag1_real", rsp_lag1_real, want.lag1_real);
               check_field("lag1_imag", rsp_lag1_imag, want.lag1_imag);
               check_field("lag2_real", rsp_lag2_real, want.lag2_real);
               check_field("lag2_imag", rsp_lag2_imag, want.lag2_imag);
               check_field("lag0_energy", {1'b0, rsp_lag0_energy},
                           {1'b0, want.lag0_energy});
            end
         end
         if (csr_write_enable) begin
            sum_length = csr_write_data;
         end
         if (req_valid && req_ready) begin
            advance_correlator(req_sample_re, req_sample_im);
         end
      end
      pending_count <= expected_results.size();
      error_count   <= mismatches;
   end

endmodule

// ----- tb/tb_complex_autocorrelator_lags_0_to_2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_autocorrelator_lags_0_to_2
// Drives complex samples into the autocorrelator under a series of sum
// lengths, starting with directed corner blocks and going on with random
// blocks, while the result side stalls on its own schedule. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_complex_autocorrelator_lags_0_to_2;
   import cac_pkg::*;

   localparam time CLK_PERIOD     = 8ns;
   localparam int  RESET_CYCLES   = 10;
   // Settling time once every result is taken; it covers samples that are
   // still in the pipeline but close nothing.
   localparam int  SETTLE_CYCLES  = 8;
   localparam int  DRAIN_CYCLES   = 16;
   localparam int  WATCHDOG_LIMIT = 1000;
   localparam int  RANDOM_ITEMS   = 800;

   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;

   // How the sample values of a random phase are drawn.
   typedef enum int {
      CONTENT_RANDOM,
      CONTENT_CORNER,
      CONTENT_FULL_SCALE,
      CONTENT_SMALL
   } content_type;

   // How the result side throttles rsp_ready.
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_RUNS
   } rx_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_sample_re = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_im = '0;

   logic                        rsp_valid;
   logic                        rsp_ready     = 1'b0;
   logic signed [ACC_W-1:0]     rsp_lag1_real;
   logic signed [ACC_W-1:0]     rsp_lag1_imag;
   logic signed [ACC_W-1:0]     rsp_lag2_real;
   logic signed [ACC_W-1:0]     rsp_lag2_imag;
   logic        [ENERGY_W-1:0]  rsp_lag0_energy;

   logic                        csr_write_enable = 1'b0;
   logic        [LEN_W-1:0]     csr_write_data   = '0;

   int   mismatch_count;
   int   results_pending;
   int   idle_cycles  = 0;
   int   burst_left   = 0;
   logic full_rate    = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   complex_autocorrelator_lags_0_to_2 i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lag1_real    (rsp_lag1_real),
      .rsp_lag1_imag    (rsp_lag1_imag),
      .rsp_lag2_real    (rsp_lag2_real),
      .rsp_lag2_imag    (rsp_lag2_imag),
      .rsp_lag0_energy  (rsp_lag0_energy),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   cac_result_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lag1_real    (rsp_lag1_real),
      .rsp_lag1_imag    (rsp_lag1_imag),
      .rsp_lag2_real    (rsp_lag2_real),
      .rsp_lag2_imag    (rsp_lag2_imag),
      .rsp_lag0_energy  (rsp_lag0_energy),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (mismatch_count),
      .pending_count    (results_pending)
   );

   // ------------------------------------------------------------------------
   // Result side. The stall style is redrawn whenever its run ends: always
   // ready, a coin toss per cycle, or long stretches of stall broken by short
   // ready windows. During full-rate phases the receiver never stalls, so the
   // block also sees stretches with no idling on either side.
   // ------------------------------------------------------------------------
   rx_style_type rx_style   = RX_ALWAYS;
   int           style_left = 0;
   int           stall_left = 0;

   always @(posedge clock) begin
      if (style_left == 0) begin
         rx_style   = rx_style_type'($urandom_range(0, 2));
         style_left = $urandom_range(40, 200);
      end
      style_left--;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (full_rate || rx_style == RX_ALWAYS) begin
         rsp_ready <= 1'b1;
      end else if (rx_style == RX_COIN) begin
         rsp_ready <= 1'($urandom_range(0, 1));
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 16);
         end
      end
   end

   // The watchdog ends a run in which no transfer happens for too long, which
   // also covers a result that never arrives at the end.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sample side. Samples go out in bursts of random length; before each
   // burst the sender may drop valid for a random gap. Once valid is high it
   // stays high, with the sample unchanged, until the transfer happens.
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!full_rate) begin
            gap = $urandom_range(0, 8);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_re <= re;
      req_sample_im <= im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   // Waits until every predicted result has been taken and the pipeline has
   // emptied, so that no sample is in flight.
   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The sum length may only change with no samples in flight. The block
   // itself may still be part way through a block, which is how a length
   // change in the middle of a block gets exercised.
   task automatic write_length(input logic [LEN_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_component(input content_type style);
      case (style)
         CONTENT_CORNER: begin
            case ($urandom_range(0, 5))
               0:       return FULL_NEG;
               1:       return FULL_NEG + 16'sd1;
               2:       return -16'sd1;
               3:       return '0;
               4:       return 16'sd1;
               default: return FULL_POS;
            endcase
         end
         // Nearly all samples at the negative full scale drive the sums to
         // their largest magnitudes.
         CONTENT_FULL_SCALE: return ($urandom_range(0, 7) == 0) ? FULL_POS : FULL_NEG;
         CONTENT_SMALL:      return $signed(SAMPLE_W'($urandom_range(0, 16))) - 16'sd8;
         default:            return SAMPLE_W'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      logic [LEN_W-1:0] new_len;
      int unsigned      eff_len;
      int               phase_items;
      int               random_sent;
      content_type      content;

      random_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // A length of zero acts as one: three samples and an all-zero result.
      write_length('0);
      send_sample(FULL_POS, FULL_NEG);
      send_sample(FULL_NEG, FULL_POS);
      send_sample(FULL_NEG, FULL_NEG);

      // Length two: each lag picks up exactly one term of extreme operands.
      write_length(LEN_W'(2));
      send_sample(16'sd12345, -16'sd1);
      send_sample(FULL_NEG, FULL_POS);
      send_sample(FULL_POS, FULL_NEG);
      send_sample(FULL_NEG, FULL_NEG);

      // Length three at full negative scale, the largest products there are.
      write_length(LEN_W'(3));
      repeat (5) send_sample(FULL_NEG, FULL_NEG);

      // Shortening the length in the middle of a block: the index is already
      // past the new end, so the next sample closes the block at once.
      write_length(LEN_W'(5));
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd1, -16'sd1);
      send_sample(-16'sd1, 16'sd1);
      send_sample(FULL_POS, 16'sd0);
      send_sample(16'sd0, FULL_NEG);
      write_length(LEN_W'(1));
      send_sample(FULL_POS, FULL_POS);

      // Random phases: each picks a length, a kind of sample content and a
      // sender pace, then sends whole blocks and sometimes a partial one that
      // the next length change cuts short or stretches.
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       new_len = '0;
            1:       new_len = LEN_W'(LEN_MIN);
            2:       new_len = LEN_W'(LEN_MAX);
            3:       new_len = {LEN_W{1'b1}};
            4, 5:    new_len = LEN_W'($urandom_range(2, 8));
            default: new_len = LEN_W'($urandom_range(0, 63));
         endcase
         write_length(new_len);
         eff_len = new_len;
         if (eff_len < LEN_MIN) eff_len = LEN_MIN;
         if (eff_len > LEN_MAX) eff_len = LEN_MAX;
         content   = content_type'($urandom_range(0, 3));
         full_rate <= ($urandom_range(0, 3) == 0);
         phase_items = $urandom_range(1, 3) * (eff_len + 2);
         if ($urandom_range(0, 2) == 0) begin
            phase_items += $urandom_range(1, eff_len + 1);
         end
         repeat (phase_items) begin
            send_sample(draw_component(content), draw_component(content));
            random_sent++;
         end
      end

      // Let every outstanding result arrive, then allow for anything extra
      // that the block might still emit.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
